### rtl/core/bfa_pkg.sv
// Shared types and constants for the bitmap frame allocator.
// No dependencies; imported by every module in rtl/core.
package bfa_pkg;

  localparam int MAX_FRAMES    = 1024;
  localparam int BITS_PER_WORD = 64;
  localparam int WORD_SLOTS    = (MAX_FRAMES + BITS_PER_WORD - 1) / BITS_PER_WORD;

  localparam int FRAME_W = $clog2(MAX_FRAMES);     // frame id
  localparam int COUNT_W = FRAME_W + 1;            // 0..MAX_FRAMES
  localparam int BIT_W   = $clog2(BITS_PER_WORD);  // bit within a word
  localparam int WIDX_W  = $clog2(WORD_SLOTS);     // word index
  localparam int WCNT_W  = WIDX_W + 1;             // word count 1..WORD_SLOTS

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_INVALID   = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [FRAME_W-1:0] request_frame;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [FRAME_W-1:0] granted_frame;
    logic               is_allocated;
    logic [COUNT_W-1:0] used_count;
    logic [COUNT_W-1:0] free_total;
  } rsp_t;

  // result of examining one bitmap word
  typedef struct packed {
    logic             full;     // no free bit
    logic             fills;    // taking the lowest free bit fills the word
    logic [BIT_W-1:0] bit_idx;  // lowest free bit
  } scan_t;

endpackage

### rtl/core/bfa_cfg_regs.sv
// APB register file holding the frame limit, clamped on write.
// Depends on bfa_pkg.
module bfa_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfa_pkg::APB_AW-1:0]  paddr,
  input  logic [bfa_pkg::APB_DW-1:0]  pwdata,
  output logic [bfa_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [bfa_pkg::COUNT_W-1:0] frame_limit_o
);
  import bfa_pkg::*;

  logic [COUNT_W-1:0] frame_limit_q, frame_limit_d, wr_val;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && !paddr[2];
  assign wr_val = pwdata[COUNT_W-1:0];

  always_comb begin
    if (wr_val == '0) begin
      frame_limit_d = COUNT_W'(1);
    end else if (wr_val > COUNT_W'(MAX_FRAMES)) begin
      frame_limit_d = COUNT_W'(MAX_FRAMES);
    end else begin
      frame_limit_d = wr_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q <= COUNT_W'(MAX_FRAMES);
    end else if (wr_en) begin
      frame_limit_q <= frame_limit_d;
    end
  end

  assign prdata        = paddr[2] ? '0 : APB_DW'(frame_limit_q);
  assign frame_limit_o = frame_limit_q;

endmodule

### rtl/core/bfa_word_unit.sv
// Shared word examiner: masks out-of-range bits in, finds the lowest free bit.
// Depends on bfa_pkg.
module bfa_word_unit (
  input  logic [bfa_pkg::BITS_PER_WORD-1:0] word_i,
  input  logic [bfa_pkg::WIDX_W-1:0]        word_idx_i,
  input  logic [bfa_pkg::COUNT_W-1:0]       frame_limit_i,
  output bfa_pkg::scan_t                    scan_o
);
  import bfa_pkg::*;

  logic [COUNT_W-1:0]       base, valid;
  logic [BITS_PER_WORD-1:0] tail, eff, free, low;
  logic [BIT_W-1:0]         idx;

  assign base  = COUNT_W'(word_idx_i) << BIT_W;
  assign valid = frame_limit_i - base;

  always_comb begin
    if (base >= frame_limit_i) begin
      tail = '1;
    end else if (valid >= COUNT_W'(BITS_PER_WORD)) begin
      tail = '0;
    end else begin
      tail = ~((BITS_PER_WORD'(1) << valid[BIT_W-1:0]) - BITS_PER_WORD'(1));
    end
  end

  assign eff  = word_i | tail;
  assign free = ~eff;
  assign low  = free & (~free + BITS_PER_WORD'(1));  // isolate lowest free bit

  // one-hot to index: each index bit ORs the positions that carry it
  always_comb begin
    idx = '0;
    for (int i = 0; i < BITS_PER_WORD; i++) begin
      if (low[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
  end

  assign scan_o.full    = (free == '0);
  assign scan_o.fills   = ((eff | low) == '1);
  assign scan_o.bit_idx = idx;

endmodule

### rtl/core/bitmap_frame_allocator.sv
// Bitmap frame allocator: top level with the sequencer and the used-bitmap.
// Depends on bfa_pkg, bfa_cfg_regs, bfa_word_unit.
//
// Usage:
//   req channel (req_valid_i/req_ready_o, req_i) takes one command word:
//   allocate, free or query. rsp channel (rsp_valid_o/rsp_ready_i, rsp_o)
//   returns exactly one result word per command, in order.
//   APB port: frame limit at address 0 (clamped to 1..MAX_FRAMES on write).
//
// Sequencing:
//   Allocate probes one bitmap word per cycle through the shared word unit,
//   starting at the remembered start word and wrapping, over at most wc
//   words (wc = words covering the frame limit, at most 16), then issues
//   the result from S_PUSH. Free/query pass S_ACCESS then S_PUSH, no-op
//   commands only S_PUSH. One command is in flight at a time; req_ready_o
//   is high only while the sequencer is idle.
//
// Reset: bitmap cleared, start word and used count zero, frame limit = max.
// Stall: the result sits in the output register while the receiver holds
//   rsp_ready_i low; the next command may still be accepted and worked, and
//   its result waits in the sequencer until the output register frees.
module bitmap_frame_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  bfa_pkg::req_t               req_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output bfa_pkg::rsp_t               rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfa_pkg::APB_AW-1:0]  paddr,
  input  logic [bfa_pkg::APB_DW-1:0]  pwdata,
  output logic [bfa_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import bfa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACCESS,
    S_PUSH
  } state_e;

  state_e              state_q;
  logic [BITS_PER_WORD-1:0] map_q [WORD_SLOTS];
  logic [WIDX_W-1:0]   start_q, idx_q, next_idx;
  logic [WCNT_W-1:0]   probes_q, wc;
  logic [COUNT_W-1:0]  used_q, frame_limit, wc_sum, free_total;
  logic [1:0]          cmd_q;
  logic [FRAME_W-1:0]  frame_q;
  status_e             res_status_q;
  logic [FRAME_W-1:0]  res_grant_q;
  logic                res_alloc_q;
  rsp_t                rsp_q;
  logic                rsp_valid_q;
  logic                rsp_load;
  logic [BITS_PER_WORD-1:0] rd_word;
  logic                rd_bit;
  scan_t               scan;

  bfa_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .frame_limit_o (frame_limit)
  );

  // single read port: scan word or the word holding the free/query frame
  assign rd_word = map_q[idx_q];
  assign rd_bit  = rd_word[frame_q[BIT_W-1:0]];

  bfa_word_unit u_word (
    .word_i        (rd_word),
    .word_idx_i    (idx_q),
    .frame_limit_i (frame_limit),
    .scan_o        (scan)
  );

  // words covering the frame limit, rounded up
  assign wc_sum   = frame_limit + COUNT_W'(BITS_PER_WORD - 1);
  assign wc       = wc_sum[COUNT_W-1:BIT_W];
  assign next_idx = ((WCNT_W'(idx_q) + WCNT_W'(1)) == wc) ? '0 : idx_q + WIDX_W'(1);

  assign free_total = (frame_limit > used_q) ? frame_limit - used_q : '0;

  // result moves into the output register when it is empty or being drained
  assign rsp_load = (state_q == S_PUSH) && (!rsp_valid_q || rsp_ready_i);

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      start_q      <= '0;
      used_q       <= '0;
      rsp_valid_q  <= 1'b0;
      idx_q        <= '0;
      probes_q     <= '0;
      cmd_q        <= CMD_ALLOC;
      frame_q      <= '0;
      res_status_q <= ST_OK;
      res_grant_q  <= '0;
      res_alloc_q  <= 1'b0;
      rsp_q        <= '0;
      for (int i = 0; i < WORD_SLOTS; i++) begin
        map_q[i] <= '0;
      end
    end else begin
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            cmd_q        <= req_i.command;
            frame_q      <= req_i.request_frame;
            probes_q     <= '0;
            res_status_q <= ST_OK;
            res_grant_q  <= '0;
            res_alloc_q  <= 1'b0;
            case (req_i.command)
              CMD_ALLOC: begin
                // a start word beyond the current word count restarts at 0
                idx_q   <= (WCNT_W'(start_q) >= wc) ? '0 : start_q;
                state_q <= S_SCAN;
              end
              CMD_FREE, CMD_QUERY: begin
                idx_q   <= req_i.request_frame[FRAME_W-1:BIT_W];
                state_q <= S_ACCESS;
              end
              default: begin
                state_q <= S_PUSH;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!scan.full) begin
            map_q[idx_q][scan.bit_idx] <= 1'b1;
            used_q      <= used_q + COUNT_W'(1);
            res_grant_q <= {idx_q, scan.bit_idx};
            start_q     <= scan.fills ? next_idx : idx_q;
            state_q     <= S_PUSH;
          end else if ((probes_q + WCNT_W'(1)) == wc) begin
            res_status_q <= ST_NO_FREE;
            state_q      <= S_PUSH;
          end else begin
            probes_q <= probes_q + WCNT_W'(1);
            idx_q    <= next_idx;
          end
        end
        S_ACCESS: begin
          if (COUNT_W'(frame_q) >= frame_limit) begin
            res_status_q <= ST_INVALID;
          end else if (cmd_q == CMD_QUERY) begin
            res_alloc_q <= rd_bit;
          end else if (!rd_bit) begin
            res_status_q <= ST_NOT_ALLOC;
          end else begin
            map_q[idx_q][frame_q[BIT_W-1:0]] <= 1'b0;
            if (used_q != '0) begin
              used_q <= used_q - COUNT_W'(1);
            end
            start_q <= idx_q;
          end
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          // counts are already updated; wait for a free output register
          if (rsp_load) begin
            rsp_q.status        <= res_status_q;
            rsp_q.granted_frame <= res_grant_q;
            rsp_q.is_allocated  <= res_alloc_q;
            rsp_q.used_count    <= used_q;
            rsp_q.free_total    <= free_total;
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sim/bfa_frame_checker.sv
`timescale 1ns / 100ps
// Frame allocator checker: keeps its own copy of the used-bitmap, predicts one
// result word per accepted command and compares it with the returned word.
// Depends on bfa_pkg; instantiated beside the allocator by the test top.
module bfa_frame_checker #(
  parameter logic [bfa_pkg::APB_AW-1:0] FLIMIT_ADDR = '0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic                       req_ready_i,
  input  bfa_pkg::req_t              req_i,
  input  logic                       rsp_valid_i,
  input  logic                       rsp_ready_i,
  input  bfa_pkg::rsp_t              rsp_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [bfa_pkg::APB_AW-1:0] paddr_i,
  input  logic [bfa_pkg::APB_DW-1:0] pwdata_i,
  input  logic [bfa_pkg::APB_DW-1:0] prdata_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import bfa_pkg::*;

  logic [BITS_PER_WORD-1:0] map_words [WORD_SLOTS];
  int   start_word;
  int   used_total;
  int   frame_cnt;
  int   fail_total;
  rsp_t owed_results [$];
  rsp_t want;

  // Apply one command to the local bitmap and return the word it should produce.
  function automatic rsp_t apply_command(req_t r);
    rsp_t                     res;
    int                       wc, first, idx, b, n;
    logic [BITS_PER_WORD-1:0] eff, tail;
    logic                     found;
    res        = '0;
    res.status = ST_OK;
    wc         = (frame_cnt + BITS_PER_WORD - 1) / BITS_PER_WORD;
    found      = 1'b0;
    case (r.command)
      CMD_ALLOC: begin
        first = (start_word >= wc) ? 0 : start_word;
        for (int p = 0; p < wc && !found; p++) begin
          idx = (first + p) % wc;
          // frames at or above the frame limit read as used
          tail = '1;
          if (idx * BITS_PER_WORD < frame_cnt) begin
            n = frame_cnt - idx * BITS_PER_WORD;
            if (n >= BITS_PER_WORD) tail = '0;
            else tail = tail << n;
          end
          eff = map_words[idx] | tail;
          if (eff != '1) begin
            b = 0;
            while (eff[b]) b++;
            map_words[idx][b] = 1'b1;
            used_total++;
            res.granted_frame = FRAME_W'(idx * BITS_PER_WORD + b);
            eff[b] = 1'b1;
            start_word = (eff == '1) ? (idx + 1) % wc : idx;
            found = 1'b1;
          end
        end
        if (!found) res.status = ST_NO_FREE;
      end
      CMD_FREE, CMD_QUERY: begin
        if (r.request_frame >= frame_cnt) begin
          res.status = ST_INVALID;
        end else begin
          idx = r.request_frame / BITS_PER_WORD;
          b   = r.request_frame % BITS_PER_WORD;
          if (r.command == CMD_QUERY) begin
            res.is_allocated = map_words[idx][b];
          end else if (!map_words[idx][b]) begin
            res.status = ST_NOT_ALLOC;
          end else begin
            map_words[idx][b] = 1'b0;
            if (used_total > 0) used_total--;
            start_word = idx;
          end
        end
      end
      default: ;  // spare command code does nothing
    endcase
    res.used_count = COUNT_W'(used_total);
    res.free_total = (frame_cnt > used_total) ? COUNT_W'(frame_cnt - used_total) : '0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (map_words[i]) map_words[i] = '0;
      start_word   = 0;
      used_total   = 0;
      frame_cnt    = MAX_FRAMES;
      fail_total   = 0;
      owed_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == FLIMIT_ADDR) begin
        if (pwrite_i) begin
          frame_cnt = pwdata_i[COUNT_W-1:0];
          if (frame_cnt == 0) frame_cnt = 1;
          if (frame_cnt > MAX_FRAMES) frame_cnt = MAX_FRAMES;
        end else if (prdata_i != APB_DW'(frame_cnt)) begin
          $error("frame limit readback expected %0d actual %0d", frame_cnt, prdata_i);
          fail_total++;
        end
      end

      // results first: a word can never answer the command taken at the same edge
      if (rsp_valid_i && rsp_ready_i) begin
        if (owed_results.size() == 0) begin
          $error("result word with nothing expected");
          fail_total++;
        end else begin
          want = owed_results.pop_front();
          if (rsp_i.status != want.status) begin
            $error("status expected %0d actual %0d", want.status, rsp_i.status);
            fail_total++;
          end
          if (rsp_i.granted_frame != want.granted_frame) begin
            $error("granted_frame expected %0d actual %0d",
                   want.granted_frame, rsp_i.granted_frame);
            fail_total++;
          end
          if (rsp_i.is_allocated != want.is_allocated) begin
            $error("is_allocated expected %0d actual %0d",
                   want.is_allocated, rsp_i.is_allocated);
            fail_total++;
          end
          if (rsp_i.used_count != want.used_count) begin
            $error("used_count expected %0d actual %0d", want.used_count, rsp_i.used_count);
            fail_total++;
          end
          if (rsp_i.free_total != want.free_total) begin
            $error("free_total expected %0d actual %0d", want.free_total, rsp_i.free_total);
            fail_total++;
          end
        end
      end

      if (req_valid_i && req_ready_i) owed_results.push_back(apply_command(req_i));

      fail_count_o <= fail_total;
      pending_o    <= owed_results.size();
    end
  end

endmodule

### sim/bitmap_frame_allocator_test.sv
`timescale 1ns / 100ps
// Test top for the bitmap frame allocator: clock, reset, command words,
// result back-pressure, frame limit writes and the verdict.
// Depends on bfa_pkg, bitmap_frame_allocator and bfa_frame_checker.
module bitmap_frame_allocator_test;
  import bfa_pkg::*;

  localparam logic [1:0]        CMD_SPARE   = 2'd3;  // unused code, acts as a no-op
  localparam logic [APB_AW-1:0] FLIMIT_ADDR = '0;    // frame limit register
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int STALL_LIMIT = 5000;  // cycles with no transfer before giving up
  localparam int DRAIN_WAIT  = 40;    // > longest allocate search plus issue

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              req_valid_i = 1'b0;
  logic              req_ready_o;
  req_t              req_i = '0;
  logic              rsp_valid_o;
  logic              rsp_ready_i = 1'b0;
  rsp_t              rsp_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int   fail_count;
  int   pending;
  int   cur_fc = MAX_FRAMES;  // frame limit as last written, clamped
  int   send_idle_pct = 0;    // only the stimulus process reads this
  int   rsp_stall_pct = 0;
  logic hold_trig = 1'b0;     // toggled to start a long hold-off
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  bitmap_frame_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  bfa_frame_checker #(.FLIMIT_ADDR(FLIMIT_ADDR)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_ready_i  (req_ready_o),
    .req_i        (req_i),
    .rsp_valid_i  (rsp_valid_o),
    .rsp_ready_i  (rsp_ready_i),
    .rsp_i        (rsp_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver: random ready, except during a hold-off that this process counts
  // itself once it sees hold_trig change.
  always @(posedge clk_i) begin
    if (hold_trig != hold_seen) begin
      hold_seen   <= hold_trig;
      hold_left   <= HOLD_CYCLES;
      rsp_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      rsp_ready_i <= 1'b0;
    end else begin
      rsp_ready_i <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Watchdog: any word moving on either channel or the config port resets it.
  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one command word and return at the edge that takes it. Valid is
  // only dropped when a gap follows, so a back-to-back word keeps it high.
  task automatic send_word(input logic [1:0] cmd, input logic [FRAME_W-1:0] frame);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_i.command       <= cmd;
    req_i.request_frame <= frame;
    req_valid_i         <= 1'b1;
    do @(posedge clk_i); while (!req_ready_o);
  endtask

  // Stop offering and wait until every owed result word has been taken.
  // The checker's count is registered, hence the wait before the first look.
  task automatic pause_sender();
    req_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Write the frame limit while idle, then read it back for the checker.
  task automatic write_frame_limit(input int unsigned value);
    pause_sender();
    cur_fc = value[COUNT_W-1:0];
    if (cur_fc == 0) cur_fc = 1;
    if (cur_fc > MAX_FRAMES) cur_fc = MAX_FRAMES;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= FLIMIT_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;  // psel stays up: this is the read's setup cycle
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random traffic: allocate-heavy so the map fills, frees and queries aimed
  // mostly at the low words where next-fit places frames.
  task automatic run_phase(input int count, input int idle, input int stall);
    int              pick, lim;
    logic [1:0]      cmd;
    logic [FRAME_W-1:0] frame;
    send_idle_pct = idle;
    rsp_stall_pct <= stall;
    lim = (cur_fc < 160) ? cur_fc : 160;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 45) cmd = CMD_ALLOC;
      else if (pick < 75) cmd = CMD_FREE;
      else if (pick < 93) cmd = CMD_QUERY;
      else cmd = CMD_SPARE;
      pick = $urandom_range(99);
      if (pick < 60) frame = FRAME_W'($urandom_range(lim - 1));
      else if (pick < 88) frame = FRAME_W'($urandom_range(cur_fc - 1));
      else frame = FRAME_W'($urandom_range(MAX_FRAMES - 1));
      send_word(cmd, frame);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single frame: zero clamps to one
    write_frame_limit(0);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_ALLOC, '0);           // nothing left
    send_word(CMD_QUERY, '0);
    send_word(CMD_QUERY, 10'd1);        // beyond the frame limit
    send_word(CMD_FREE, 10'd1);
    send_word(CMD_FREE, '0);
    send_word(CMD_FREE, '0);            // already free
    send_word(CMD_SPARE, '1);
    send_word(CMD_QUERY, '1);

    // over-range write clamps to the maximum
    write_frame_limit(2047);
    send_word(CMD_ALLOC, '1);
    send_word(CMD_ALLOC, 10'h2AA);
    send_word(CMD_QUERY, '1);
    send_word(CMD_FREE, '1);
    send_word(CMD_QUERY, 10'h2AA);
    send_word(CMD_FREE, 10'h155);
    send_word(CMD_FREE, '0);
    send_word(CMD_ALLOC, '0);           // start word rewound: frame 0 again
    send_word(CMD_QUERY, '0);
    send_word(CMD_SPARE, 10'h155);

    run_phase(200, 0, 0);
    write_frame_limit(64);              // shrink below what is already taken
    run_phase(150, 77, 0);
    write_frame_limit(130);
    run_phase(150, 0, 77);

    // long hold-off while the sender keeps pushing, so input backs up
    hold_trig <= ~hold_trig;
    run_phase(12, 0, 0);
    pause_sender();

    write_frame_limit(200);
    run_phase(150, 25, 25);
    write_frame_limit(1024);
    run_phase(300, 0, 0);
    write_frame_limit(1000);
    run_phase(150, 25, 25);

    pause_sender();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
